// ===== sv/udpf_pkg.sv =====
// Package for the UDP/IPv4 frame builder: constants, descriptor and register types,
// and the small byte-selection and decimal helpers. Depends on nothing.
package udpf_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic REG_SOURCE_MAC = 1'b0;
   localparam logic REG_SOURCE_IP  = 1'b1;

   localparam logic [47:0] SOURCE_MAC_RESET = 48'h761C_A1A2_1B41;
   localparam logic [31:0] SOURCE_IP_RESET  = 32'h0A00_0011;

   localparam logic [15:0] ETHER_TYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  IP_VER_IHL      = 8'h45;
   localparam logic [7:0]  IP_PROTO_UDP    = 8'd17;
   localparam logic [7:0]  ASCII_ZERO      = 8'h30;
   // Fixed header words 0x4500, id 0x0001 and ttl/protocol 0x0011 summed together.
   localparam logic [18:0] CSUM_FIXED      = 19'h0_4512;
   localparam logic [7:0]  TOT_LEN_SHORT   = 8'd29;
   localparam logic [7:0]  UDP_LEN_SHORT   = 8'd9;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [47:0] source_mac;
      logic [31:0] source_ip;
   } csr_regs_type;

   typedef struct packed {
      logic [47:0] dest_mac;
      logic [31:0] dest_ip;
      logic [15:0] udp_port;
      logic [15:0] checksum;
      logic [7:0]  digit_first;
      logic [7:0]  digit_second;
      logic        short_frame;
   } frame_desc_type;

   function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
      logic [7:0] b;
      case (k)
         3'd0:    b = mac[47:40];
         3'd1:    b = mac[39:32];
         3'd2:    b = mac[31:24];
         3'd3:    b = mac[23:16];
         3'd4:    b = mac[15:8];
         default: b = mac[7:0];
      endcase
      return b;
   endfunction

   function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] k);
      logic [7:0] b;
      case (k)
         2'd0:    b = ip[31:24];
         2'd1:    b = ip[23:16];
         2'd2:    b = ip[15:8];
         default: b = ip[7:0];
      endcase
      return b;
   endfunction

   function automatic logic [2:0] decimal_tens(input logic [5:0] v);
      logic [2:0] t;
      if (v >= 6'd60)      t = 3'd6;
      else if (v >= 6'd50) t = 3'd5;
      else if (v >= 6'd40) t = 3'd4;
      else if (v >= 6'd30) t = 3'd3;
      else if (v >= 6'd20) t = 3'd2;
      else if (v >= 6'd10) t = 3'd1;
      else                 t = 3'd0;
      return t;
   endfunction

endpackage

// ===== sv/udpf_ifs.sv =====
// Request and response channel interfaces of the UDP/IPv4 frame builder.
// Valid/ready handshake; no dependencies.
interface udpf_req_if;
   logic        valid;
   logic        ready;
   logic [47:0] dest_mac;
   logic [31:0] dest_ip;
   logic [15:0] udp_port;
   logic [5:0]  seq_number;

   modport source (output valid, dest_mac, dest_ip, udp_port, seq_number, input ready);
   modport sink   (input valid, dest_mac, dest_ip, udp_port, seq_number, output ready);
endinterface

interface udpf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_last;

   modport source (output valid, frame_byte, frame_last, input ready);
   modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface

// ===== sv/udp_ipv4_frame_builder.sv =====
// Top level of the UDP/IPv4 frame builder: configuration registers, front end,
// descriptor queue and byte-serial back end. Depends on udpf_pkg and udpf_ifs.
//
// Each request on req_bus (destination MAC, destination IPv4 address, UDP port and
// sequence number) becomes one Ethernet/IPv4/UDP frame on rsp_bus, one byte per
// response, in wire order, with frame_last set on the final payload byte.
// A frame is 43 bytes when the sequence number is below ten and 44 bytes otherwise.
// A frame's first byte passes the front-end register, a queue entry, the back end's
// cur_ff and the response register. The back end sends one byte per cycle while
// rsp_bus is not stalled, and the next frame follows without a gap; the byte walk
// of the back end sets this rate. The front end and a two-entry queue accept up to
// three further requests while a frame is being sent. The source MAC and source
// IPv4 address are written over the csr_ port at byte addresses 0 and 8; the user
// must write them only while no frame is in progress, which the block does not
// enforce. Reset clears the front end, the queue and the response stage, and restores
// the default source addresses. When the receiver holds rsp_ready low, the current
// byte is held and the back end, then the queue, then req_ready stall in turn.
module udp_ipv4_frame_builder
   import udpf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   udpf_req_if.sink              req_bus,
   udpf_rsp_if.source            rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   csr_regs_type   regs;
   logic           front_valid;
   logic           front_ready;
   frame_desc_type front_desc;
   logic           queue_valid;
   logic           queue_ready;
   frame_desc_type queue_desc;

   udpf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .regs        (regs)
   );

   udpf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .source_ip  (regs.source_ip),
      .desc_valid (front_valid),
      .desc_ready (front_ready),
      .desc       (front_desc)
   );

   udpf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_desc   (front_desc),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_desc  (queue_desc)
   );

   udpf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (queue_valid),
      .desc_ready (queue_ready),
      .desc       (queue_desc),
      .regs       (regs),
      .rsp_bus    (rsp_bus)
   );

endmodule

// ===== sv/udpf_csr.sv =====
// Configuration registers of the frame builder behind an APB-style write/read port.
// Depends on udpf_pkg.
module udpf_csr
   import udpf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output csr_regs_type          regs
);

   logic [47:0] source_mac_ff;
   logic [31:0] source_ip_ff;
   logic        wr_en;
   logic        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         source_mac_ff <= SOURCE_MAC_RESET;
         source_ip_ff  <= SOURCE_IP_RESET;
      end else if (wr_en) begin
         if (reg_sel == REG_SOURCE_MAC) begin
            source_mac_ff <= csr_pwdata[47:0];
         end else begin
            source_ip_ff <= csr_pwdata[31:0];
         end
      end
   end

   always_comb begin
      if (reg_sel == REG_SOURCE_MAC) begin
         csr_prdata = {16'd0, source_mac_ff};
      end else begin
         csr_prdata = {32'd0, source_ip_ff};
      end
   end

   assign regs.source_mac = source_mac_ff;
   assign regs.source_ip  = source_ip_ff;

endmodule

// ===== sv/udpf_front.sv =====
// Front end of the frame builder: accepts a request, works out the IPv4 header checksum
// and the ASCII digits, and registers a frame descriptor. Uses udpf_pkg and udpf_ifs.
module udpf_front
   import udpf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   udpf_req_if.sink       req_bus,
   input  logic [31:0]    source_ip,
   output logic           desc_valid,
   input  logic           desc_ready,
   output frame_desc_type desc
);

   logic           valid_ff;
   logic           valid_in;
   frame_desc_type desc_ff;
   frame_desc_type desc_in;
   logic           take;
   logic           short_frame;
   logic [2:0]     tens;
   logic [5:0]     ones;
   logic [18:0]    sum;
   logic [16:0]    fold1;
   logic [15:0]    fold2;

   assign req_bus.ready = !valid_ff || desc_ready;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      short_frame = req_bus.seq_number < 6'd10;
      tens        = decimal_tens(req_bus.seq_number);
      ones        = req_bus.seq_number - 6'(6'(tens) * 6'd10);
      sum = CSUM_FIXED + 19'(short_frame ? TOT_LEN_SHORT : TOT_LEN_SHORT + 8'd1)
          + 19'(source_ip[31:16]) + 19'(source_ip[15:0])
          + 19'(req_bus.dest_ip[31:16]) + 19'(req_bus.dest_ip[15:0]);
      fold1 = 17'(sum[18:16]) + 17'(sum[15:0]);
      fold2 = fold1[15:0] + 16'(fold1[16]);

      desc_in.dest_mac     = req_bus.dest_mac;
      desc_in.dest_ip      = req_bus.dest_ip;
      desc_in.udp_port     = req_bus.udp_port;
      desc_in.checksum     = ~fold2;
      desc_in.short_frame  = short_frame;
      desc_in.digit_first  = short_frame ? ASCII_ZERO + 8'(ones) : ASCII_ZERO + 8'(tens);
      desc_in.digit_second = ASCII_ZERO + 8'(ones);
   end

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (desc_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         desc_ff <= desc_in;
      end
   end

   assign desc_valid = valid_ff;
   assign desc       = desc_ff;

endmodule

// ===== sv/udpf_queue.sv =====
// Two-entry descriptor queue between the front and back ends of the frame builder.
// Depends on udpf_pkg.
module udpf_queue
   import udpf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  frame_desc_type in_desc,
   output logic           out_valid,
   input  logic           out_ready,
   output frame_desc_type out_desc
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_desc_type        mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  push;
   logic                  pop;

   assign in_ready  = count_ff != CNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_desc  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_desc;
      end
   end

endmodule

// ===== sv/udpf_back.sv =====
// Back end of the frame builder: walks a descriptor byte by byte in wire order into a
// registered response stage. Depends on udpf_pkg and udpf_ifs.
module udpf_back
   import udpf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           desc_valid,
   output logic           desc_ready,
   input  frame_desc_type desc,
   input  csr_regs_type   regs,
   udpf_rsp_if.source     rsp_bus
);

   frame_desc_type cur_ff;
   logic           active_ff;
   logic           active_in;
   logic [5:0]     idx_ff;
   logic [5:0]     idx_in;
   logic           out_valid_ff;
   logic           out_valid_in;
   logic [7:0]     out_byte_ff;
   logic           out_last_ff;
   logic           advance;
   logic           emit;
   logic           is_last;
   logic           load;
   logic [7:0]     sel_byte;
   logic [5:0]     off_smac;
   logic [5:0]     off_sip;
   logic [5:0]     off_dip;
   logic [7:0]     len_low;

   assign advance    = !out_valid_ff || rsp_bus.ready;
   assign emit       = active_ff && advance;
   assign is_last    = cur_ff.short_frame ? (idx_ff == 6'd42) : (idx_ff == 6'd43);
   assign load       = !active_ff || (emit && is_last);
   assign desc_ready = load;

   assign off_smac = idx_ff - 6'd6;
   assign off_sip  = idx_ff - 6'd26;
   assign off_dip  = idx_ff - 6'd30;

   always_comb begin
      len_low = cur_ff.short_frame ? UDP_LEN_SHORT : UDP_LEN_SHORT + 8'd1;
      case (idx_ff) inside
         [6'd0:6'd5]:   sel_byte = mac_byte(cur_ff.dest_mac, idx_ff[2:0]);
         [6'd6:6'd11]:  sel_byte = mac_byte(regs.source_mac, off_smac[2:0]);
         6'd12:         sel_byte = ETHER_TYPE_IPV4[15:8];
         6'd13:         sel_byte = ETHER_TYPE_IPV4[7:0];
         6'd14:         sel_byte = IP_VER_IHL;
         6'd17: begin
            sel_byte = cur_ff.short_frame ? TOT_LEN_SHORT : TOT_LEN_SHORT + 8'd1;
         end
         6'd19:         sel_byte = 8'd1;
         6'd23:         sel_byte = IP_PROTO_UDP;
         6'd24:         sel_byte = cur_ff.checksum[15:8];
         6'd25:         sel_byte = cur_ff.checksum[7:0];
         [6'd26:6'd29]: sel_byte = ip_byte(regs.source_ip, off_sip[1:0]);
         [6'd30:6'd33]: sel_byte = ip_byte(cur_ff.dest_ip, off_dip[1:0]);
         6'd34, 6'd36:  sel_byte = cur_ff.udp_port[15:8];
         6'd35, 6'd37:  sel_byte = cur_ff.udp_port[7:0];
         6'd39:         sel_byte = len_low;
         6'd42:         sel_byte = cur_ff.digit_first;
         6'd43:         sel_byte = cur_ff.digit_second;
         default:       sel_byte = 8'd0;
      endcase
   end

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      if (load) begin
         active_in = desc_valid;
         idx_in    = '0;
      end else if (emit) begin
         idx_in = idx_ff + 6'd1;
      end
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && desc_valid) begin
         cur_ff <= desc;
      end
      if (emit) begin
         out_byte_ff <= sel_byte;
         out_last_ff <= is_last;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.frame_byte = out_byte_ff;
   assign rsp_bus.frame_last = out_last_ff;

endmodule

// ===== sv/udpf_checker.sv =====
// Port-level checker for the UDP/IPv4 frame builder and the bind that attaches it.
// Depends on the top level udp_ipv4_frame_builder.
module udpf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_frame_byte,
   input logic       rsp_frame_last
);

   logic [5:0] pos_ff;
   logic [5:0] pos_in;
   logic       out_take;

   assign out_take = rsp_valid && rsp_ready;

   always_comb begin
      pos_in = pos_ff;
      if (out_take) begin
         pos_in = rsp_frame_last ? 6'd0 : pos_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_byte)
                                  && $stable(rsp_frame_last))
      else $error("Stalled response changed.");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      out_take && rsp_frame_last |-> pos_ff == 6'd42 || pos_ff == 6'd43)
      else $error("Frame end at a wrong length.");

   a_max_len: assert property (@(posedge clock) disable iff (reset)
      out_take && !rsp_frame_last |-> pos_ff < 6'd43)
      else $error("Frame longer than the largest frame.");

   a_ether_type: assert property (@(posedge clock) disable iff (reset)
      out_take && pos_ff == 6'd12 |-> rsp_frame_byte == 8'h08)
      else $error("Ethernet type byte wrong.");

endmodule

bind udp_ipv4_frame_builder udpf_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_frame_byte (rsp_bus.frame_byte),
   .rsp_frame_last (rsp_bus.frame_last)
);
